/* design/hct_pkg.sv */
`timescale 1ns / 1ps

package hct_pkg;

  localparam int CNT_W   = 5;
  localparam int ID_W    = 22;
  localparam int ST_W    = 4;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // event kinds
  localparam logic [2:0] EV_ADDED     = 3'd0;
  localparam logic [2:0] EV_KNOWN     = 3'd1;
  localparam logic [2:0] EV_UNREG     = 3'd2;
  localparam logic [2:0] EV_OFFLINE   = 3'd3;
  localparam logic [2:0] EV_EVICTED   = 3'd4;
  localparam logic [2:0] EV_SWEEPDONE = 3'd5;

  // commands
  localparam logic CMD_STATUS = 1'b0;
  localparam logic CMD_SWEEP  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_CODE = 4'd1;

  typedef struct packed {
    logic              command;
    logic [ID_W-1:0]   client_id;
    logic [ST_W-1:0]   status_code;
    logic [TIME_W-1:0] now_time;
  } hct_in_t;

  typedef struct packed {
    logic [2:0]       event_kind;
    logic [CNT_W-1:0] slot_index;
    logic [ID_W-1:0]  client_out;
    logic [ST_W-1:0]  status_out;
    logic [CNT_W-1:0] active_count;
    logic             last_result;
  } hct_out_t;

  // per-cell update controls, mutually exclusive
  typedef struct packed {
    logic load;   // take new id and time
    logic touch;  // refresh time only
    logic shift;  // take neighbor's contents
  } hct_cell_ctl_t;

endpackage

/* design/hct_cell.sv */
`timescale 1ns / 1ps

module hct_cell
  import hct_pkg::*;
(
  input  logic              clk,
  input  hct_cell_ctl_t     ctl,
  input  logic [ID_W-1:0]   query_id,
  input  logic [TIME_W-1:0] now_time,
  input  logic [TMO_W-1:0]  timeout,
  input  logic [ID_W-1:0]   nb_id,
  input  logic [TIME_W-1:0] nb_heard,
  output logic [ID_W-1:0]   id_o,
  output logic [TIME_W-1:0] heard_o,
  output logic              match_o,
  output logic              idle_o
);

  logic [ID_W-1:0]   id_r,    id_nxt;
  logic [TIME_W-1:0] heard_r, heard_nxt;
  logic [TIME_W-1:0] silence;

  always_comb begin
    id_nxt    = id_r;
    heard_nxt = heard_r;
    if (ctl.shift) begin
      id_nxt    = nb_id;
      heard_nxt = nb_heard;
    end else if (ctl.load) begin
      id_nxt    = query_id;
      heard_nxt = now_time;
    end else if (ctl.touch) begin
      heard_nxt = now_time;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    heard_r <= heard_nxt;
  end

  // wrapping difference
  assign silence = now_time - heard_r;
  assign idle_o  = silence > {{(TIME_W-TMO_W){1'b0}}, timeout};
  assign match_o = id_r == query_id;
  assign id_o    = id_r;
  assign heard_o = heard_r;

endmodule

/* design/heartbeat_client_table.sv */
`timescale 1ns / 1ps

// Heartbeat client table: a compact, ordered table of up to SLOTS client ids,
// each kept in its own cell together with the time it was last heard from.
// Start a command while busy is low. For a status message, its one result
// shows on out_data with out_valid for one cycle, registered from the
// message state, and busy is low again in that same cycle. A sweep walks
// a single scan pointer down the row of cells, one cell per cycle; the
// pointer stays on a slot after an eviction, as the next entry slides in.
// It stays busy until it gives its final done result. It gives one result
// per eviction plus that done result, at most one result per cycle.
// Results are never held: out_valid is a strobe and the receiver must take
// every item in the cycle it appears. Removing an entry shifts every cell
// above it down by one, so the table stays packed. Configuration writes
// are always ready and should only be issued while busy is low.
module heartbeat_client_table
  import hct_pkg::*;
#(
  parameter int SLOTS = 16
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  hct_in_t               in_data,
  output logic                  out_valid,
  output hct_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  typedef enum logic [1:0] {ST_IDLE, ST_MSG, ST_SWEEP} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [ID_W-1:0]   id_r;
  logic [ST_W-1:0]   status_r;
  logic [TIME_W-1:0] now_r;
  logic [TMO_W-1:0]  timeout_r;
  logic [ST_W-1:0]   offline_r;
  logic              out_valid_r;
  hct_out_t          out_data_r;

  // cell row
  hct_cell_ctl_t     cell_ctl   [SLOTS];
  logic [ID_W-1:0]   cell_id    [SLOTS];
  logic [TIME_W-1:0] cell_heard [SLOTS];
  logic [SLOTS-1:0]  cell_match;
  logic [SLOTS-1:0]  cell_idle;

  // decision signals
  logic              hit;
  logic [CNT_W-1:0]  hit_idx;
  logic              sel_idle;
  logic [ID_W-1:0]   sel_id;
  logic              rm_en;
  logic [CNT_W-1:0]  rm_idx;
  logic              app_en;
  logic              touch_en;
  logic              ev_valid;
  logic              sweep_end;
  hct_out_t          ev;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      logic [ID_W-1:0]   nb_id;
      logic [TIME_W-1:0] nb_heard;
      if (g < SLOTS - 1) begin : g_nb
        assign nb_id    = cell_id[g+1];
        assign nb_heard = cell_heard[g+1];
      end else begin : g_top
        // top cell never shifts
        assign nb_id    = cell_id[g];
        assign nb_heard = cell_heard[g];
      end
      hct_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[g]),
        .query_id (id_r),
        .now_time (now_r),
        .timeout  (timeout_r),
        .nb_id    (nb_id),
        .nb_heard (nb_heard),
        .id_o     (cell_id[g]),
        .heard_o  (cell_heard[g]),
        .match_o  (cell_match[g]),
        .idle_o   (cell_idle[g])
      );
    end
  endgenerate

  always_comb begin
    // lowest occupied slot that matches
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (cell_match[j] && (CNT_W'(j) < cnt_r)) begin
        hit     = 1'b1;
        hit_idx = CNT_W'(j);
      end
    end
    // cell under the scan pointer
    sel_idle = 1'b0;
    sel_id   = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (CNT_W'(j) == ptr_r) begin
        sel_idle = cell_idle[j];
        sel_id   = cell_id[j];
      end
    end

    rm_en     = 1'b0;
    rm_idx    = hit_idx;
    app_en    = 1'b0;
    touch_en  = 1'b0;
    ev_valid  = 1'b0;
    sweep_end = 1'b0;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    ev        = '0;

    case (state_r)
      ST_IDLE: begin
        // scan starts at the bottom cell
        ptr_nxt = '0;
      end
      ST_MSG: begin
        ev_valid       = 1'b1;
        ev.client_out  = id_r;
        ev.status_out  = status_r;
        ev.last_result = 1'b1;
        if (hit) begin
          ev.slot_index = hit_idx;
          if (status_r == offline_r) begin
            rm_en         = 1'b1;
            cnt_nxt       = cnt_r - CNT_W'(1);
            ev.event_kind = EV_OFFLINE;
          end else begin
            touch_en      = 1'b1;
            ev.event_kind = EV_KNOWN;
          end
        end else if (status_r == '0 && cnt_r < SLOTS_C) begin
          app_en        = 1'b1;
          cnt_nxt       = cnt_r + CNT_W'(1);
          ev.slot_index = cnt_r;
          ev.event_kind = EV_ADDED;
        end else begin
          ev.slot_index = SLOTS_C;
          ev.event_kind = EV_UNREG;
        end
      end
      ST_SWEEP: begin
        rm_idx = ptr_r;
        if (ptr_r < cnt_r) begin
          if (sel_idle) begin
            // evict; next entry slides into this slot, pointer stays
            rm_en         = 1'b1;
            cnt_nxt       = cnt_r - CNT_W'(1);
            ev_valid      = 1'b1;
            ev.event_kind = EV_EVICTED;
            ev.slot_index = ptr_r;
            ev.client_out = sel_id;
          end else begin
            ptr_nxt = ptr_r + CNT_W'(1);
          end
        end else begin
          sweep_end      = 1'b1;
          ev_valid       = 1'b1;
          ev.event_kind  = EV_SWEEPDONE;
          ev.slot_index  = SLOTS_C;
          ev.last_result = 1'b1;
        end
      end
      default: begin
      end
    endcase
    ev.active_count = cnt_nxt;

    for (int j = 0; j < SLOTS; j++) begin
      cell_ctl[j].load  = app_en && (CNT_W'(j) == cnt_r);
      cell_ctl[j].touch = touch_en && (CNT_W'(j) == hit_idx);
      cell_ctl[j].shift = rm_en && (CNT_W'(j) >= rm_idx) && (j < SLOTS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      timeout_r   <= TMO_W'(35);
      offline_r   <= ST_W'(6);
    end else begin
      out_valid_r <= ev_valid;
      out_data_r  <= ev;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= (in_data.command == CMD_SWEEP) ? ST_SWEEP : ST_MSG;
          end
        end
        ST_MSG: begin
          state_r <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (sweep_end) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IDLE_TIMEOUT: timeout_r <= cfg_data;
          CFG_OFFLINE_CODE: offline_r <= cfg_data[ST_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // item registers need no reset
  always_ff @(posedge clk) begin
    if (start && state_r == ST_IDLE) begin
      id_r     <= in_data.client_id;
      status_r <= in_data.status_code;
      now_r    <= in_data.now_time;
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLOTS_C)
    else $error("entry count above table size");

  // only evictions are non-final results
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind != EV_EVICTED |-> out_data.last_result)
    else $error("final flag missing on result");

  // returning to idle always coincides with the final result
  a_idle_final: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_data.last_result)
    else $error("went idle without final result");

  // final result means the block is ready again
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |-> !busy)
    else $error("still busy after final result");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import hct_pkg::*;

  localparam int TBL_SLOTS = 16;
  localparam int POOL_N    = 24;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  hct_in_t               in_data = '0;
  logic                  out_valid;
  hct_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  heartbeat_client_table #(
    .SLOTS(TBL_SLOTS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the client table: packed slots 0..mirror_count-1, plus the
  // register values currently in force.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]   mirror_ids   [TBL_SLOTS];
  logic [TIME_W-1:0] mirror_heard [TBL_SLOTS];
  int unsigned       mirror_count = 0;
  logic [TMO_W-1:0]  cur_timeout  = 16'd35;
  logic [ST_W-1:0]   cur_offline  = 4'd6;

  hct_out_t expected_events [$];
  hct_in_t  pending_items   [$];

  int unsigned items_sent = 0;   // items put on the bus by the driver
  int unsigned items_taken = 0;  // items the block accepted
  int          mismatch_count = 0;

  // Stimulus state
  logic [ID_W-1:0]   id_pool [POOL_N];
  logic [TIME_W-1:0] gen_clock = '0;

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic void push_event(logic [2:0] kind, int unsigned slot,
                                     logic [ID_W-1:0] who, logic [ST_W-1:0] st,
                                     logic last);
    hct_out_t ev;
    ev.event_kind   = kind;
    ev.slot_index   = CNT_W'(slot);
    ev.client_out   = who;
    ev.status_out   = st;
    ev.active_count = CNT_W'(mirror_count);  // count after this result
    ev.last_result  = last;
    expected_events.push_back(ev);
  endfunction

  // Remove one entry and slide everything above it down a slot.
  function automatic void drop_entry(int unsigned slot);
    for (int unsigned j = slot; j + 1 < mirror_count; j++) begin
      mirror_ids[j]   = mirror_ids[j + 1];
      mirror_heard[j] = mirror_heard[j + 1];
    end
    if (mirror_count > 0) mirror_count--;
  endfunction

  // Work out the events one accepted item produces and queue them.
  function automatic void forecast_events(hct_in_t it);
    int unsigned       slot;
    bit                hit;
    logic [TIME_W-1:0] silence;
    logic [ID_W-1:0]   who;
    if (it.command == CMD_STATUS) begin
      hit  = 1'b0;
      slot = 0;
      for (int unsigned i = 0; i < mirror_count; i++) begin
        if (!hit && mirror_ids[i] == it.client_id) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        mirror_heard[slot] = it.now_time;
        if (it.status_code == cur_offline) begin
          drop_entry(slot);
          push_event(EV_OFFLINE, slot, it.client_id, it.status_code, 1'b1);
        end else begin
          push_event(EV_KNOWN, slot, it.client_id, it.status_code, 1'b1);
        end
      end else if (it.status_code == '0 && mirror_count < TBL_SLOTS) begin
        slot = mirror_count;
        mirror_ids[slot]   = it.client_id;
        mirror_heard[slot] = it.now_time;
        mirror_count++;
        push_event(EV_ADDED, slot, it.client_id, it.status_code, 1'b1);
      end else begin
        push_event(EV_UNREG, TBL_SLOTS, it.client_id, it.status_code, 1'b1);
      end
    end else begin
      // Sweep: after an eviction the same slot holds the next entry, so the
      // index only moves on when an entry survives.
      slot = 0;
      while (slot < mirror_count) begin
        silence = it.now_time - mirror_heard[slot];
        if (silence > TIME_W'(cur_timeout)) begin
          who = mirror_ids[slot];
          drop_entry(slot);
          push_event(EV_EVICTED, slot, who, '0, 1'b0);
        end else begin
          slot++;
        end
      end
      push_event(EV_SWEEPDONE, TBL_SLOTS, '0, '0, 1'b1);
    end
  endfunction

  task automatic check_field(string name, logic [31:0] got,
                             logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. Results are checked
  // before a new item is forecast; either order gives the same queue.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hct_out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_events.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d slot %0d client 0x%0h",
                                  out_data.event_kind, out_data.slot_index,
                                  out_data.client_out));
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind",   32'(out_data.event_kind),   32'(want.event_kind));
          check_field("slot_index",   32'(out_data.slot_index),   32'(want.slot_index));
          check_field("client_out",   32'(out_data.client_out),   32'(want.client_out));
          check_field("status_out",   32'(out_data.status_out),   32'(want.status_out));
          check_field("active_count", 32'(out_data.active_count), 32'(want.active_count));
          check_field("last_result",  32'(out_data.last_result),  32'(want.last_result));
        end
      end
      if (start && !busy) begin
        items_taken++;
        forecast_events(in_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: works on the falling edge. An item stays on the bus until the
  // monitor has counted it as taken; then a random gap may follow. Now and
  // then a calm stretch runs items back to back.
  // ---------------------------------------------------------------------------
  bit drv_on = 1'b0;
  int gap_left = 0;
  int calm_left = 0;

  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (drv_on && items_taken == items_sent) begin
        drv_on   = 1'b0;
        gap_left = pick_gap();
      end
      if (!drv_on) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          items_sent++;
          drv_on = 1'b1;
        end
      end
      start <= drv_on;  // single assignment per edge keeps back-to-back items high
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_msg(logic [ID_W-1:0] id, logic [ST_W-1:0] st,
                         logic [TIME_W-1:0] t);
    hct_in_t it;
    it.command     = CMD_STATUS;
    it.client_id   = id;
    it.status_code = st;
    it.now_time    = t;
    pending_items.push_back(it);
  endtask

  task automatic add_sweep(logic [TIME_W-1:0] t);
    hct_in_t it;
    it.command     = CMD_SWEEP;
    it.client_id   = ID_W'($urandom());  // ignored on a sweep, so noise
    it.status_code = ST_W'($urandom());
    it.now_time    = t;
    pending_items.push_back(it);
  endtask

  // Mostly a small pool of recurring clients on a slowly advancing clock, so
  // ids hit, refresh, drop out and get evicted; the rest is fresh random ids
  // and big jumps in time (wraparound included).
  task automatic queue_random(int n, int sweep_pct, int off_pct);
    hct_in_t it;
    int      roll;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 5) gen_clock = TIME_W'($urandom());
      else gen_clock = gen_clock + TIME_W'($urandom_range(0, 12));
      it.command = ($urandom_range(0, 99) < sweep_pct) ? CMD_SWEEP : CMD_STATUS;
      if ($urandom_range(0, 99) < 75)
        it.client_id = id_pool[$urandom_range(0, POOL_N - 1)];
      else
        it.client_id = ID_W'($urandom());
      roll = $urandom_range(0, 99);
      if (roll < off_pct) it.status_code = cur_offline;
      else if (roll < 60) it.status_code = '0;
      else it.status_code = ST_W'($urandom());
      it.now_time = gen_clock;
      pending_items.push_back(it);
    end
  endtask

  // Everything sent, taken and answered; then a margin for the longest sweep.
  task automatic wait_drained();
    while (pending_items.size() != 0 || items_taken != items_sent ||
           expected_events.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write, only while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == CFG_IDLE_TIMEOUT) cur_timeout = val;
    else if (idx == CFG_OFFLINE_CODE) cur_offline = val[ST_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < POOL_N; k++) id_pool[k] = ID_W'($urandom());

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset register values (timeout 35, offline 6).
    add_sweep(32'd0);                         // empty table: done only
    add_msg('0, 4'd0, 32'd100);               // id zero is a normal id
    add_msg('1, 4'd0, 32'hFFFF_FFF0);         // max id, time about to wrap
    for (int k = 2; k < TBL_SLOTS; k++)
      add_msg(ID_W'(22'h2AAAAA - k), 4'd0, TIME_W'(100 + 2 * k));
    add_msg(22'h000777, 4'd0, 32'd132);       // table full: unregistered
    add_msg('0, 4'hF, 32'd133);               // known id, status refresh
    add_msg(ID_W'(22'h2AAAAA - 5), 4'd6, 32'd134);  // offline from mid table
    add_msg(22'h123456, 4'd6, 32'd135);       // unknown going offline
    add_sweep(32'd150);                       // wrapped entry plus a run of old ones
    add_sweep(32'd150);                       // nothing left to evict
    wait_drained();

    // Timeout zero and offline code zero.
    write_reg(CFG_IDLE_TIMEOUT, 16'd0);
    write_reg(CFG_OFFLINE_CODE, 16'd0);
    add_msg('0, 4'd0, 32'd200);               // known id with status 0 leaves
    add_msg('0, 4'd0, 32'd201);               // and comes back
    add_msg('1, 4'd0, 32'd201);
    add_msg('1, 4'd5, 32'd202);
    add_sweep(32'd201);                       // only same-second entries stay
    gen_clock = 32'd300;
    queue_random(40, 15, 15);
    wait_drained();

    // Longest timeout, top offline code, few sweeps so the table fills up.
    write_reg(CFG_IDLE_TIMEOUT, 16'hFFFF);
    write_reg(CFG_OFFLINE_CODE, 16'd15);
    queue_random(60, 5, 5);
    wait_drained();

    write_reg(CFG_IDLE_TIMEOUT, 16'd1);
    write_reg(CFG_OFFLINE_CODE, 16'd9);
    queue_random(50, 20, 15);
    wait_drained();

    write_reg(CFG_IDLE_TIMEOUT, 16'($urandom_range(2, 200)));
    write_reg(CFG_OFFLINE_CODE, 16'($urandom_range(0, 15)));
    queue_random(70, 15, 15);
    wait_drained();

    write_reg(CFG_IDLE_TIMEOUT, 16'd35);
    write_reg(CFG_OFFLINE_CODE, 16'd6);
    queue_random(70, 15, 20);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("heartbeat_client_table test passed");
    end else begin
      $display("heartbeat_client_table test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("heartbeat_client_table test failed");
    $finish;
  end

endmodule

/* sim.f */
design/hct_pkg.sv
design/hct_cell.sv
design/heartbeat_client_table.sv
dv/tb_top.sv
